// ----- sv/truss_decomposition_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the truss decomposition block.
// Each macro checks one implication on the rising edge of clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef TRUSS_DECOMPOSITION_TOP_ASSERT_SVH
`define TRUSS_DECOMPOSITION_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("truss decomposition check failed");

// Consequent must hold in the cycle after the antecedent.
`define TRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("truss decomposition check failed");

`endif

// ----- sv/trd_pkg.sv -----
// ----------------------------------------------------------------------------
// trd_pkg
// Types and constants shared by the truss decomposition modules.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int NUM_VERTICES = 64;
  localparam int NUM_EDGES    = 1024;
  localparam int VW = 6;   // vertex number
  localparam int EW = 10;  // edge number
  localparam int CW = 11;  // edge count
  localparam int PW = 12;  // vertex pair address
  localparam int SW = 6;   // support
  localparam int TW = 7;   // trussness

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_NOT_READY = 3'd4;

  localparam logic [TW-1:0] BASE_TRUSS = 7'd2;
  localparam logic [VW-1:0] V_LAST     = VW'(NUM_VERTICES - 1);
  localparam logic [CW-1:0] EDGES_MAX  = CW'(NUM_EDGES);

  typedef struct packed {
    logic [1:0]    operation;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
    logic [EW-1:0] edge_index;
  } in_t;

  typedef struct packed {
    logic [TW-1:0] edge_trussness;
    logic [2:0]    status;
    logic [CW-1:0] edge_count;
  } out_t;

  typedef enum logic [1:0] {
    K_ADD     = 2'd0,
    K_COMPUTE = 2'd1,
    K_READ    = 2'd2,
    K_NOP     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t         kind;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [EW-1:0] idx;
  } cmd_t;

endpackage

// ----- sv/trd_ram.sv -----
// ----------------------------------------------------------------------------
// trd_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module trd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- sv/trd_fifo.sv -----
// ----------------------------------------------------------------------------
// trd_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module trd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/trd_front.sv -----
// ----------------------------------------------------------------------------
// trd_front
// Takes requests, decodes the operation into a command and queues it.
// ----------------------------------------------------------------------------
module trd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  trd_pkg::in_t  item,
  input  logic          hold,
  output logic          full,
  output trd_pkg::cmd_t cmd,
  output logic          cmd_empty,
  input  logic          cmd_pop
);

  trd_pkg::cmd_t cmd_in;
  logic          q_full;
  logic          q_push;

  always_comb begin
    cmd_in.a   = item.vertex_a;
    cmd_in.b   = item.vertex_b;
    cmd_in.idx = item.edge_index;
    case (item.operation)
      trd_pkg::OP_ADD:     cmd_in.kind = trd_pkg::K_ADD;
      trd_pkg::OP_COMPUTE: cmd_in.kind = trd_pkg::K_COMPUTE;
      trd_pkg::OP_READ:    cmd_in.kind = trd_pkg::K_READ;
      default:             cmd_in.kind = trd_pkg::K_NOP;
    endcase
  end

  // Intake is closed while the back end clears its pair table.
  assign full   = q_full || hold;
  assign q_push = push && !full;

  trd_fifo #(
    .WIDTH ($bits(trd_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

// ----- sv/trd_back.sv -----
// ----------------------------------------------------------------------------
// trd_back
// Executes commands: edge load, support count and peeling, trussness read.
// ----------------------------------------------------------------------------
module trd_back (
  input  logic          clk,
  input  logic          rst,
  input  trd_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output trd_pkg::out_t res,
  output logic          clearing
);

  typedef enum logic [15:0] {
    S_CLEAR    = 16'h0001,
    S_IDLE     = 16'h0002,
    S_ADD_CHK  = 16'h0004,
    S_ADD_WR2  = 16'h0008,
    S_RD_WAIT  = 16'h0010,
    S_CNT_EP   = 16'h0020,
    S_CNT_RD   = 16'h0040,
    S_CNT_CHK  = 16'h0080,
    S_CNT_WR   = 16'h0100,
    S_PL_ISSUE = 16'h0200,
    S_PL_CHECK = 16'h0400,
    S_SD_RD    = 16'h0800,
    S_SD_PAIR  = 16'h1000,
    S_SD_ST    = 16'h2000,
    S_SD_WR2   = 16'h4000,
    S_SD_DONE  = 16'h8000
  } state_t;

  state_t                     state;
  logic [trd_pkg::PW-1:0]     clr;
  logic [trd_pkg::CW-1:0]     total;
  logic                       ready;
  logic [trd_pkg::VW-1:0]     op_a;
  logic [trd_pkg::VW-1:0]     op_b;
  logic [trd_pkg::EW-1:0]     ptr;
  logic [trd_pkg::VW-1:0]     w;
  logic [trd_pkg::SW-1:0]     s;
  logic [trd_pkg::SW-1:0]     top;
  logic [trd_pkg::SW-1:0]     level;
  logic                       found;
  logic [trd_pkg::EW-1:0]     e1;
  logic [trd_pkg::EW-1:0]     e2;
  logic                       dec2;
  logic [trd_pkg::SW-1:0]     sup2_new;

  logic                       dispatch;
  logic [trd_pkg::VW-1:0]     u;
  logic [trd_pkg::VW-1:0]     v;
  logic                       ptr_last;
  logic                       w_last;
  logic                       w_skip;

  // Pair table: edge number + 1 for each ordered vertex pair.
  logic                       pr_we;
  logic [trd_pkg::PW-1:0]     pr_waddr;
  logic [trd_pkg::CW-1:0]     pr_wdata;
  logic [trd_pkg::PW-1:0]     pr_raddr0;
  logic [trd_pkg::PW-1:0]     pr_raddr1;
  logic [trd_pkg::CW-1:0]     pr_rdata0;
  logic [trd_pkg::CW-1:0]     pr_rdata1;
  // Endpoints of each edge.
  logic                       ep_we;
  logic [2*trd_pkg::VW-1:0]   ep_rdata;
  // Finished flag and current support of each edge.
  logic                       st_we;
  logic [trd_pkg::EW-1:0]     st_waddr;
  logic [trd_pkg::SW:0]       st_wdata;
  logic [trd_pkg::EW-1:0]     st_raddr0;
  logic [trd_pkg::EW-1:0]     st_raddr1;
  logic [trd_pkg::SW:0]       st_rdata0;
  logic [trd_pkg::SW:0]       st_rdata1;
  // Trussness of each edge.
  logic                       tr_we;
  logic [trd_pkg::TW-1:0]     tr_wdata;
  logic [trd_pkg::TW-1:0]     tr_rdata;

  assign u        = ep_rdata[2*trd_pkg::VW-1:trd_pkg::VW];
  assign v        = ep_rdata[trd_pkg::VW-1:0];
  assign ptr_last = (({1'b0, ptr} + 1'b1) == total);
  assign w_last   = (w == trd_pkg::V_LAST);
  assign w_skip   = (w == u) || (w == v);
  assign dispatch = (state == S_IDLE) && !cmd_empty && !res_full;
  assign cmd_pop  = dispatch;
  assign clearing = (state == S_CLEAR);

  always_comb begin
    pr_raddr0 = (state == S_IDLE) ? {cmd.a, cmd.b} : {u, w};
    pr_raddr1 = {v, w};
    st_raddr0 = (state == S_SD_PAIR) ? trd_pkg::EW'(pr_rdata0 - 1'b1) : ptr;
    st_raddr1 = trd_pkg::EW'(pr_rdata1 - 1'b1);

    pr_we    = 1'b0;
    pr_waddr = clr;
    pr_wdata = '0;
    ep_we    = 1'b0;
    st_we    = 1'b0;
    st_waddr = ptr;
    st_wdata = {1'b0, s};
    tr_we    = 1'b0;
    tr_wdata = trd_pkg::BASE_TRUSS;
    res_push = 1'b0;
    res.edge_trussness = '0;
    res.status         = trd_pkg::ST_OK;
    res.edge_count     = total;

    case (state)
      S_CLEAR: begin
        pr_we = 1'b1;
      end
      S_IDLE: begin
        if (dispatch) begin
          case (cmd.kind)
            trd_pkg::K_ADD: begin
              if (total == trd_pkg::EDGES_MAX) begin
                res_push   = 1'b1;
                res.status = trd_pkg::ST_FULL;
              end
            end
            trd_pkg::K_COMPUTE: begin
              res_push = (total == '0);
            end
            trd_pkg::K_READ: begin
              if ({1'b0, cmd.idx} >= total) begin
                res_push   = 1'b1;
                res.status = trd_pkg::ST_BAD_INDEX;
              end else if (!ready) begin
                res_push   = 1'b1;
                res.status = trd_pkg::ST_NOT_READY;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_ADD_CHK: begin
        if (pr_rdata0 != '0) begin
          res_push   = 1'b1;
          res.status = trd_pkg::ST_DUP;
        end else begin
          pr_we    = 1'b1;
          pr_waddr = {op_a, op_b};
          pr_wdata = total + 1'b1;
          ep_we    = 1'b1;
        end
      end
      S_ADD_WR2: begin
        pr_we          = 1'b1;
        pr_waddr       = {op_b, op_a};
        pr_wdata       = total + 1'b1;
        res_push       = 1'b1;
        res.edge_count = total + 1'b1;
      end
      S_RD_WAIT: begin
        res_push           = 1'b1;
        res.edge_trussness = tr_rdata;
      end
      S_CNT_WR: begin
        st_we    = 1'b1;
        st_wdata = {(s == '0), s};
        tr_we    = (s == '0);
      end
      S_PL_ISSUE: begin
        res_push = (level > top);
      end
      S_SD_ST: begin
        if (!st_rdata0[trd_pkg::SW] && !st_rdata1[trd_pkg::SW] &&
            (st_rdata0[trd_pkg::SW-1:0] > level)) begin
          st_we    = 1'b1;
          st_waddr = e1;
          st_wdata = {1'b0, st_rdata0[trd_pkg::SW-1:0] - 1'b1};
        end
      end
      S_SD_WR2: begin
        st_we    = dec2;
        st_waddr = e2;
        st_wdata = {1'b0, sup2_new};
      end
      S_SD_DONE: begin
        st_we    = 1'b1;
        st_wdata = {1'b1, level};
        tr_we    = 1'b1;
        tr_wdata = trd_pkg::TW'(level) + trd_pkg::BASE_TRUSS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      total <= '0;
      ready <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (dispatch) begin
            op_a <= cmd.a;
            op_b <= cmd.b;
            case (cmd.kind)
              trd_pkg::K_ADD: begin
                if (total != trd_pkg::EDGES_MAX) begin
                  state <= S_ADD_CHK;
                end
              end
              trd_pkg::K_COMPUTE: begin
                if (total == '0) begin
                  ready <= 1'b1;
                end else begin
                  ptr   <= '0;
                  top   <= '0;
                  state <= S_CNT_EP;
                end
              end
              trd_pkg::K_READ: begin
                if (({1'b0, cmd.idx} < total) && ready) begin
                  state <= S_RD_WAIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_CHK: begin
          state <= (pr_rdata0 != '0) ? S_IDLE : S_ADD_WR2;
        end
        S_ADD_WR2: begin
          total <= total + 1'b1;
          ready <= 1'b0;
          state <= S_IDLE;
        end
        S_RD_WAIT: begin
          state <= S_IDLE;
        end
        S_CNT_EP: begin
          w     <= '0;
          s     <= '0;
          state <= S_CNT_RD;
        end
        S_CNT_RD: begin
          if (u == v) begin
            state <= S_CNT_WR;
          end else if (!w_skip) begin
            state <= S_CNT_CHK;
          end else if (w_last) begin
            state <= S_CNT_WR;
          end else begin
            w <= w + 1'b1;
          end
        end
        S_CNT_CHK: begin
          if ((pr_rdata0 != '0) && (pr_rdata1 != '0)) begin
            s <= s + 1'b1;
          end
          if (w_last) begin
            state <= S_CNT_WR;
          end else begin
            w     <= w + 1'b1;
            state <= S_CNT_RD;
          end
        end
        S_CNT_WR: begin
          if (s > top) begin
            top <= s;
          end
          if (ptr_last) begin
            ptr   <= '0;
            level <= trd_pkg::SW'(1);
            found <= 1'b0;
            state <= S_PL_ISSUE;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_CNT_EP;
          end
        end
        S_PL_ISSUE: begin
          if (level > top) begin
            ready <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_PL_CHECK;
          end
        end
        S_PL_CHECK: begin
          if (!st_rdata0[trd_pkg::SW] && (st_rdata0[trd_pkg::SW-1:0] == level)) begin
            w     <= '0;
            state <= S_SD_RD;
          end else begin
            if (ptr_last) begin
              ptr   <= '0;
              found <= 1'b0;
              if (!found) begin
                level <= level + 1'b1;
              end
            end else begin
              ptr <= ptr + 1'b1;
            end
            state <= S_PL_ISSUE;
          end
        end
        S_SD_RD: begin
          if (!w_skip) begin
            state <= S_SD_PAIR;
          end else if (w_last) begin
            state <= S_SD_DONE;
          end else begin
            w <= w + 1'b1;
          end
        end
        S_SD_PAIR: begin
          e1 <= trd_pkg::EW'(pr_rdata0 - 1'b1);
          e2 <= trd_pkg::EW'(pr_rdata1 - 1'b1);
          if ((pr_rdata0 != '0) && (pr_rdata1 != '0)) begin
            state <= S_SD_ST;
          end else if (w_last) begin
            state <= S_SD_DONE;
          end else begin
            w     <= w + 1'b1;
            state <= S_SD_RD;
          end
        end
        S_SD_ST: begin
          dec2     <= !st_rdata0[trd_pkg::SW] && !st_rdata1[trd_pkg::SW] &&
                      (st_rdata1[trd_pkg::SW-1:0] > level);
          sup2_new <= st_rdata1[trd_pkg::SW-1:0] - 1'b1;
          state    <= S_SD_WR2;
        end
        S_SD_WR2: begin
          if (w_last) begin
            state <= S_SD_DONE;
          end else begin
            w     <= w + 1'b1;
            state <= S_SD_RD;
          end
        end
        S_SD_DONE: begin
          found <= 1'b1;
          state <= S_PL_ISSUE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  trd_ram #(
    .WIDTH (trd_pkg::CW),
    .DEPTH (trd_pkg::NUM_VERTICES * trd_pkg::NUM_VERTICES)
  ) u_pair_ram (
    .clk    (clk),
    .we     (pr_we),
    .waddr  (pr_waddr),
    .wdata  (pr_wdata),
    .raddr0 (pr_raddr0),
    .raddr1 (pr_raddr1),
    .rdata0 (pr_rdata0),
    .rdata1 (pr_rdata1)
  );

  trd_ram #(
    .WIDTH (2 * trd_pkg::VW),
    .DEPTH (trd_pkg::NUM_EDGES)
  ) u_ep_ram (
    .clk    (clk),
    .we     (ep_we),
    .waddr  (total[trd_pkg::EW-1:0]),
    .wdata  ({op_a, op_b}),
    .raddr0 (ptr),
    .raddr1 (ptr),
    .rdata0 (ep_rdata),
    .rdata1 ()
  );

  trd_ram #(
    .WIDTH (trd_pkg::SW + 1),
    .DEPTH (trd_pkg::NUM_EDGES)
  ) u_state_ram (
    .clk    (clk),
    .we     (st_we),
    .waddr  (st_waddr),
    .wdata  (st_wdata),
    .raddr0 (st_raddr0),
    .raddr1 (st_raddr1),
    .rdata0 (st_rdata0),
    .rdata1 (st_rdata1)
  );

  trd_ram #(
    .WIDTH (trd_pkg::TW),
    .DEPTH (trd_pkg::NUM_EDGES)
  ) u_truss_ram (
    .clk    (clk),
    .we     (tr_we),
    .waddr  (ptr),
    .wdata  (tr_wdata),
    .raddr0 (cmd.idx),
    .raddr1 (cmd.idx),
    .rdata0 (tr_rdata),
    .rdata1 ()
  );

endmodule

// ----- sv/truss_decomposition_top.sv -----
// ----------------------------------------------------------------------------
// truss_decomposition_top
// Loads an undirected graph edge by edge and computes each edge's trussness.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload
//   request   push / full      item   (operation, vertex_a, vertex_b, edge_index)
//   result    pop / empty      result (edge_trussness, status, edge_count)
//
// After rst the pair table is swept to zero, one entry per cycle; full stays
// high while the sweep runs. An add request passes through a check state and
// a second write state, since both orders of the vertex pair go through the
// single write port of the pair table; a read waits on the registered
// trussness memory; an immediate answer is pushed when the command is taken.
// A compute request first counts the support of each edge by checking every
// other vertex (a self-loop skips this), then scans the edges for every level
// and again after each pass that peeled an edge; for each peeled edge it checks
// every other vertex, updates the triangle's two other edges, then finishes it.
// The request queue keeps taking up to two requests while the back end works,
// and a two-entry result queue lets results wait for pop without blocking.

module truss_decomposition_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  trd_pkg::in_t  item,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output trd_pkg::out_t result
);

  trd_pkg::cmd_t cmd;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          res_full;
  logic          res_push;
  trd_pkg::out_t res;
  logic          clearing;

  // The front end decodes each request and queues it as a command.
  trd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .hold      (clearing),
    .full      (full),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop)
  );

  // The back end owns all graph storage and runs one command at a time. It
  // only starts a command when the result queue has room, so every command
  // can deliver its single result without stalling.
  trd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .clearing  (clearing)
  );

  // Results wait here until they are popped.
  trd_fifo #(
    .WIDTH ($bits(trd_pkg::out_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

`include "truss_decomposition_top_assert.svh"

  // No request may be taken while the pair table is being cleared.
  `TRD_ASSERT_SAME(a_clear_blocks_intake, clearing, full)
  // The back end never pushes into a full result queue.
  `TRD_ASSERT_SAME(a_no_result_overflow, res_push, !res_full)
  // A nonzero trussness only comes with a good status.
  `TRD_ASSERT_SAME(a_truss_only_ok, !empty && (result.edge_trussness != '0),
                   result.status == trd_pkg::ST_OK)
  // The edge count never passes the table size.
  `TRD_ASSERT_SAME(a_count_bound, !empty, result.edge_count <= trd_pkg::EDGES_MAX)

endmodule
